[design/aarch64_table_walk_translate_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the table walk translate unit
// Concurrent checks that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef AARCH64_TABLE_WALK_TRANSLATE_UNIT_ASSERT_SVH
`define AARCH64_TABLE_WALK_TRANSLATE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

// cond must never hold
`define ATWT_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

// ante implies cons in the same cycle
`define ATWT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// ante implies cons in the next cycle
`define ATWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define ATWT_ASSERT_NEVER(label, clk, rst, cond, msg)
`define ATWT_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define ATWT_ASSERT_NEXT(label, clk, rst, ante, cons, msg)

`endif

`endif

[design/atwt_pkg.sv]
// ----------------------------------------------------------------------------
// atwt_pkg
// Types and constants shared by the table walk translate unit.
// ----------------------------------------------------------------------------
`default_nettype none

package atwt_pkg;

   localparam int ADDR_W  = 64;
   localparam int PERMS_W = 6;
   localparam int FAULT_W = 2;
   localparam int LEVEL_W = 2;
   localparam int CSR_IDX_W = 2;

   // input beat function
   localparam logic FUNC_REQUEST    = 1'b0;
   localparam logic FUNC_DESCRIPTOR = 1'b1;

   // result kind
   localparam logic KIND_READ = 1'b0;
   localparam logic KIND_DONE = 1'b1;

   // fault codes
   localparam logic [FAULT_W-1:0] FAULT_NONE  = 2'd0;
   localparam logic [FAULT_W-1:0] FAULT_READ  = 2'd1;
   localparam logic [FAULT_W-1:0] FAULT_WRITE = 2'd2;
   localparam logic [FAULT_W-1:0] FAULT_FETCH = 2'd3;

   // descriptor type field
   localparam logic [1:0] DESC_BLOCK = 2'd1;
   localparam logic [1:0] DESC_TABLE = 2'd3;

   // permission groups
   localparam logic [PERMS_W-1:0] PERM_READ  = 6'h03;
   localparam logic [PERMS_W-1:0] PERM_WRITE = 6'h0c;
   localparam logic [PERMS_W-1:0] PERM_FETCH = 6'h30;

   localparam logic [LEVEL_W-1:0] LEVEL_FIRST = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_LAST  = 2'd2;

   localparam logic [ADDR_W-1:0] VA_HALF_SPLIT = 64'h0000_8000_0000_0000;

   // configuration register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_TRANSLATE_ENABLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_TABLE_BASE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_TABLE_BASE  = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_CNT_W = 2;

   typedef struct packed {
      logic                translate_enable;
      logic [ADDR_W-1:0]   low_table_base;
      logic [ADDR_W-1:0]   high_table_base;
   } atwt_cfg_type;

   typedef struct packed {
      logic                busy;
      logic [LEVEL_W-1:0]  level;
      logic [ADDR_W-1:0]   vaddr;
      logic [PERMS_W-1:0]  perms;
   } atwt_walk_type;

   typedef struct packed {
      logic                kind;
      logic [ADDR_W-1:0]   read_addr;
      logic [ADDR_W-1:0]   phys_addr;
      logic [PERMS_W-1:0]  granted_perms;
      logic [FAULT_W-1:0]  fault_code;
      logic                resolved;
   } atwt_rsp_type;

endpackage

`default_nettype wire

[design/aarch64_table_walk_translate_unit.sv]
// ----------------------------------------------------------------------------
// aarch64_table_walk_translate_unit
// Virtual address translation by a 4 KiB granule table walk ending in
// 2 MiB blocks; issues descriptor reads and takes returned descriptors.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  func, virt_addr, want_perms, descriptor
//   rsp      out        rsp_valid/rsp_stall  kind, read_addr, phys_addr, granted_perms,
//                                            fault_code, resolved
//   csr      in         csr_write_enable     csr_index, csr_write_data
//
// One beat a cycle on req while req_stall is low; the step is decoded in the cycle of acceptance and its
// result reaches rsp from the result register.
// The result register plus one skid entry hold up to two results; req_stall rises
// only when both are occupied.
// Reset clears the walk busy flag and level, the configuration registers and empties the result queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aarch64_table_walk_translate_unit_assert.svh"

module aarch64_table_walk_translate_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire logic                          req_func,
   input  wire logic [atwt_pkg::ADDR_W-1:0]    req_virt_addr,
   input  wire logic [atwt_pkg::PERMS_W-1:0]   req_want_perms,
   input  wire logic [atwt_pkg::ADDR_W-1:0]    req_descriptor,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output logic                               rsp_kind,
   output logic [atwt_pkg::ADDR_W-1:0]         rsp_read_addr,
   output logic [atwt_pkg::ADDR_W-1:0]         rsp_phys_addr,
   output logic [atwt_pkg::PERMS_W-1:0]        rsp_granted_perms,
   output logic [atwt_pkg::FAULT_W-1:0]        rsp_fault_code,
   output logic                               rsp_resolved,
   input  wire logic                          csr_write_enable,
   input  wire logic [atwt_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [atwt_pkg::ADDR_W-1:0]    csr_write_data
);

   atwt_pkg::atwt_cfg_type  cfg_ff, cfg_in;
   atwt_pkg::atwt_walk_type walk_ff, walk_in, step_walk;
   atwt_pkg::atwt_rsp_type  step_rsp, out_rsp;
   logic step_valid;
   logic accept;
   logic queue_full;

   assign accept    = req_valid && !req_stall;
   assign req_stall = queue_full;

   atwt_step u_step (
      .func         (req_func),
      .virt_addr    (req_virt_addr),
      .want_perms   (req_want_perms),
      .descriptor   (req_descriptor),
      .cfg          (cfg_ff),
      .walk         (walk_ff),
      .result_valid (step_valid),
      .result       (step_rsp),
      .walk_next    (step_walk)
   );

   atwt_rsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (accept && step_valid),
      .push_data (step_rsp),
      .full      (queue_full),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (out_rsp)
   );

   assign rsp_kind          = out_rsp.kind;
   assign rsp_read_addr     = out_rsp.read_addr;
   assign rsp_phys_addr     = out_rsp.phys_addr;
   assign rsp_granted_perms = out_rsp.granted_perms;
   assign rsp_fault_code    = out_rsp.fault_code;
   assign rsp_resolved      = out_rsp.resolved;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            atwt_pkg::CSR_TRANSLATE_ENABLE: cfg_in.translate_enable = csr_write_data[0];
            atwt_pkg::CSR_LOW_TABLE_BASE:   cfg_in.low_table_base   = csr_write_data;
            atwt_pkg::CSR_HIGH_TABLE_BASE:  cfg_in.high_table_base  = csr_write_data;
            default:                        cfg_in                  = cfg_ff;
         endcase
      end
   end

   // hold walk state unless a beat is taken
   assign walk_in = accept ? step_walk : walk_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= '0;
         walk_ff.busy  <= 1'b0;
         walk_ff.level <= atwt_pkg::LEVEL_FIRST;
      end else begin
         cfg_ff        <= cfg_in;
         walk_ff.busy  <= walk_in.busy;
         walk_ff.level <= walk_in.level;
      end
      walk_ff.vaddr <= walk_in.vaddr;
      walk_ff.perms <= walk_in.perms;
   end

   `ATWT_ASSERT_IMPLY(a_level_range, clock, reset, walk_ff.busy, walk_ff.level <= atwt_pkg::LEVEL_LAST, "walk level out of range")
   `ATWT_ASSERT_NEXT(a_last_level_ends, clock, reset, accept && req_func == atwt_pkg::FUNC_DESCRIPTOR && walk_ff.busy && walk_ff.level == atwt_pkg::LEVEL_LAST, !walk_ff.busy, "walk continues past last level")
   `ATWT_ASSERT_NEXT(a_bypass_idle, clock, reset, accept && req_func == atwt_pkg::FUNC_REQUEST && !cfg_ff.translate_enable, !walk_ff.busy, "walk started while disabled")
   `ATWT_ASSERT_IMPLY(a_idle_desc_silent, clock, reset, accept && req_func == atwt_pkg::FUNC_DESCRIPTOR && !walk_ff.busy, !step_valid, "result from idle descriptor")

endmodule

`default_nettype wire

[design/atwt_step.sv]
// ----------------------------------------------------------------------------
// atwt_step
// One walk step: decodes a request or a returned descriptor against the
// current walk state and gives the result and the next walk state.
// ----------------------------------------------------------------------------
`default_nettype none

module atwt_step (
   input  wire logic                        func,
   input  wire logic [atwt_pkg::ADDR_W-1:0]  virt_addr,
   input  wire logic [atwt_pkg::PERMS_W-1:0] want_perms,
   input  wire logic [atwt_pkg::ADDR_W-1:0]  descriptor,
   input  wire atwt_pkg::atwt_cfg_type       cfg,
   input  wire atwt_pkg::atwt_walk_type      walk,
   output logic                              result_valid,
   output atwt_pkg::atwt_rsp_type            result,
   output atwt_pkg::atwt_walk_type           walk_next
);

   // table index of va at a level: bits 47:39, 38:30, 29:21
   function automatic logic [8:0] level_index(
      input logic [atwt_pkg::ADDR_W-1:0]  va,
      input logic [atwt_pkg::LEVEL_W-1:0] level
   );
      logic [8:0] idx;
      case (level)
         2'd0:    idx = va[47:39];
         2'd1:    idx = va[38:30];
         default: idx = va[29:21];
      endcase
      return idx;
   endfunction

   logic [atwt_pkg::ADDR_W-1:0]  base;
   logic [1:0]                   desc_type;
   logic [atwt_pkg::LEVEL_W-1:0] level_inc;

   assign desc_type = descriptor[1:0];
   assign level_inc = atwt_pkg::LEVEL_W'(walk.level + 2'd1);
   assign base      = (virt_addr < atwt_pkg::VA_HALF_SPLIT) ? cfg.low_table_base
                                                             : cfg.high_table_base;

   always_comb begin
      result_valid = 1'b0;
      result       = '0;
      walk_next    = walk;
      if (func == atwt_pkg::FUNC_REQUEST) begin
         // a request abandons any running walk
         result_valid   = 1'b1;
         walk_next.busy = 1'b0;
         if (!cfg.translate_enable) begin
            result.kind          = atwt_pkg::KIND_DONE;
            result.phys_addr     = virt_addr;
            result.granted_perms = want_perms;
            result.resolved      = 1'b1;
         end else begin
            walk_next.busy   = 1'b1;
            walk_next.level  = atwt_pkg::LEVEL_FIRST;
            walk_next.vaddr  = virt_addr;
            walk_next.perms  = want_perms;
            result.kind      = atwt_pkg::KIND_READ;
            result.read_addr = {base[63:12],
                                level_index(virt_addr, atwt_pkg::LEVEL_FIRST), 3'b000};
         end
      end else if (walk.busy) begin
         result_valid = 1'b1;
         if (walk.level >= atwt_pkg::LEVEL_LAST) begin
            walk_next.busy = 1'b0;
            result.kind    = atwt_pkg::KIND_DONE;
            if (desc_type == atwt_pkg::DESC_BLOCK) begin
               result.phys_addr     = {16'h0000, descriptor[47:12], 12'h000}
                                    | {43'h0, walk.vaddr[20:0]};
               result.granted_perms = walk.perms;
               result.resolved      = 1'b1;
            end
         end else if (desc_type == atwt_pkg::DESC_TABLE) begin
            walk_next.level  = level_inc;
            result.kind      = atwt_pkg::KIND_READ;
            result.read_addr = {16'h0000, descriptor[47:12],
                                level_index(walk.vaddr, level_inc), 3'b000};
         end else begin
            // block too early or invalid entry: walk ends either way
            walk_next.busy = 1'b0;
            result.kind    = atwt_pkg::KIND_DONE;
            if (desc_type != atwt_pkg::DESC_BLOCK) begin
               if ((walk.perms & atwt_pkg::PERM_WRITE) != '0) begin
                  result.fault_code = atwt_pkg::FAULT_WRITE;
                  result.resolved   = 1'b1;
               end else if ((walk.perms & atwt_pkg::PERM_READ) != '0) begin
                  result.fault_code = atwt_pkg::FAULT_READ;
                  result.resolved   = 1'b1;
               end else if ((walk.perms & atwt_pkg::PERM_FETCH) != '0) begin
                  result.fault_code = atwt_pkg::FAULT_FETCH;
                  result.resolved   = 1'b1;
               end
            end
         end
      end
   end

endmodule

`default_nettype wire

[design/atwt_rsp_queue.sv]
// ----------------------------------------------------------------------------
// atwt_rsp_queue
// Result register with one skid entry; parts the request side from the
// response side so a new beat is taken while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "aarch64_table_walk_translate_unit_assert.svh"

module atwt_rsp_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire atwt_pkg::atwt_rsp_type push_data,
   output logic                        full,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output atwt_pkg::atwt_rsp_type      rsp_data
);

   localparam logic [atwt_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
      atwt_pkg::QUEUE_CNT_W'(atwt_pkg::QUEUE_DEPTH);

   atwt_pkg::atwt_rsp_type head_ff, head_in;
   atwt_pkg::atwt_rsp_type skid_ff, skid_in;
   logic [atwt_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;
   logic pop;

   assign rsp_valid = (count_ff != '0);
   assign rsp_data  = head_ff;
   assign full      = (count_ff == CNT_FULL);
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      head_in  = head_ff;
      skid_in  = skid_ff;
      count_in = count_ff;
      if (count_ff == CNT_FULL) begin
         // advance skid into head
         if (pop) begin
            head_in  = skid_ff;
            count_in = 2'd1;
         end
      end else if (count_ff == 2'd1) begin
         if (push && pop) begin
            head_in = push_data;
         end else if (push) begin
            skid_in  = push_data;
            count_in = CNT_FULL;
         end else if (pop) begin
            count_in = 2'd0;
         end
      end else if (push) begin
         head_in  = push_data;
         count_in = 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

   `ATWT_ASSERT_NEVER(a_count_range, clock, reset, count_ff > CNT_FULL, "queue overfilled")
   `ATWT_ASSERT_NEVER(a_push_full, clock, reset, push && full, "push into full queue")
   `ATWT_ASSERT_NEXT(a_pop_drains, clock, reset, pop && !push, count_ff == $past(count_ff) - 2'd1, "pop lost")

endmodule

`default_nettype wire

[bench/aarch64_table_walk_translate_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table walk translation checker
// Watches the request, result and register ports of the translate unit. It
// keeps its own copy of the walk state and the registers, works out the
// result of every accepted request or descriptor beat, and compares each
// result beat in order against what it expects.
// ----------------------------------------------------------------------------
module aarch64_table_walk_translate_checker
   import atwt_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_func,
   input  logic [ADDR_W-1:0]    req_virt_addr,
   input  logic [PERMS_W-1:0]   req_want_perms,
   input  logic [ADDR_W-1:0]    req_descriptor,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic                 rsp_kind,
   input  logic [ADDR_W-1:0]    rsp_read_addr,
   input  logic [ADDR_W-1:0]    rsp_phys_addr,
   input  logic [PERMS_W-1:0]   rsp_granted_perms,
   input  logic [FAULT_W-1:0]   rsp_fault_code,
   input  logic                 rsp_resolved,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [ADDR_W-1:0]    csr_write_data,
   output int                   mismatch_count,
   output int                   pending_results
);

   logic              walk_enable;
   logic [ADDR_W-1:0] low_base;
   logic [ADDR_W-1:0] high_base;
   atwt_walk_type     walk;
   atwt_rsp_type      expected_walk_results[$];
   int                mismatches = 0;

   initial begin
      mismatch_count = 0;
      pending_results = 0;
   end

   // byte offset of the descriptor that a level indexes
   function automatic logic [ADDR_W-1:0] entry_offset(input logic [ADDR_W-1:0] va,
                                                      input logic [LEVEL_W-1:0] level);
      logic [8:0] idx;
      if (level == LEVEL_FIRST) begin
         idx = va[47:39];
      end else if (level >= LEVEL_LAST) begin
         idx = va[29:21];
      end else begin
         idx = va[38:30];
      end
      return {52'd0, idx, 3'd0};
   endfunction

   function automatic atwt_rsp_type make_result(input logic kind,
                                                input logic [ADDR_W-1:0] ra,
                                                input logic [ADDR_W-1:0] pa,
                                                input logic [PERMS_W-1:0] perms,
                                                input logic [FAULT_W-1:0] fault,
                                                input logic resolved);
      atwt_rsp_type r;
      r.kind = kind;
      r.read_addr = ra;
      r.phys_addr = pa;
      r.granted_perms = perms;
      r.fault_code = fault;
      r.resolved = resolved;
      return r;
   endfunction

   function automatic logic [ADDR_W-1:0] next_table(input logic [ADDR_W-1:0] desc);
      return {16'd0, desc[47:12], 12'd0};
   endfunction

   task automatic predict_translation(input logic func,
                                      input logic [ADDR_W-1:0] va,
                                      input logic [PERMS_W-1:0] want,
                                      input logic [ADDR_W-1:0] desc);
      logic [ADDR_W-1:0]  base;
      logic [1:0]         dtype;
      logic [FAULT_W-1:0] fault;
      if (func == FUNC_REQUEST) begin
         // a new request drops any walk in flight
         walk.busy = 1'b0;
         if (!walk_enable) begin
            expected_walk_results.push_back(
               make_result(KIND_DONE, '0, va, want, FAULT_NONE, 1'b1));
         end else begin
            base = (va < VA_HALF_SPLIT) ? low_base : high_base;
            base[11:0] = '0;
            walk.busy = 1'b1;
            walk.level = LEVEL_FIRST;
            walk.vaddr = va;
            walk.perms = want;
            expected_walk_results.push_back(
               make_result(KIND_READ, base + entry_offset(va, LEVEL_FIRST), '0, '0,
                           FAULT_NONE, 1'b0));
         end
      end else if (walk.busy) begin
         dtype = desc[1:0];
         if (walk.level >= LEVEL_LAST) begin
            walk.busy = 1'b0;
            if (dtype == DESC_BLOCK) begin
               expected_walk_results.push_back(
                  make_result(KIND_DONE, '0,
                              next_table(desc) | {43'd0, walk.vaddr[20:0]},
                              walk.perms, FAULT_NONE, 1'b1));
            end else begin
               expected_walk_results.push_back(
                  make_result(KIND_DONE, '0, '0, '0, FAULT_NONE, 1'b0));
            end
         end else if (dtype == DESC_TABLE) begin
            walk.level = walk.level + 1'b1;
            expected_walk_results.push_back(
               make_result(KIND_READ, next_table(desc) + entry_offset(walk.vaddr, walk.level),
                           '0, '0, FAULT_NONE, 1'b0));
         end else begin
            walk.busy = 1'b0;
            fault = FAULT_NONE;
            if (dtype != DESC_BLOCK) begin
               if (|(walk.perms & PERM_WRITE)) begin
                  fault = FAULT_WRITE;
               end else if (|(walk.perms & PERM_READ)) begin
                  fault = FAULT_READ;
               end else if (|(walk.perms & PERM_FETCH)) begin
                  fault = FAULT_FETCH;
               end
            end
            // a fault still resolves; an early block or an empty request fails
            expected_walk_results.push_back(
               make_result(KIND_DONE, '0, '0, '0, fault, fault != FAULT_NONE));
         end
      end
   endtask

   task automatic compare_field(input string name, input logic [ADDR_W-1:0] exp,
                                input logic [ADDR_W-1:0] got);
      if (exp !== got) begin
         $error("%s: expected %0h, actual %0h", name, exp, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin : watch
      atwt_rsp_type exp;
      if (reset) begin
         walk_enable = 1'b0;
         low_base = '0;
         high_base = '0;
         walk = '0;
         expected_walk_results.delete();
      end else begin
         // retire the result beat before booking this edge's request beat
         if (rsp_valid && !rsp_stall) begin
            if (expected_walk_results.size() == 0) begin
               $error("result beat with no translation outstanding");
               mismatches++;
            end else begin
               exp = expected_walk_results.pop_front();
               compare_field("kind", exp.kind, rsp_kind);
               compare_field("read_addr", exp.read_addr, rsp_read_addr);
               compare_field("phys_addr", exp.phys_addr, rsp_phys_addr);
               compare_field("granted_perms", exp.granted_perms, rsp_granted_perms);
               compare_field("fault_code", exp.fault_code, rsp_fault_code);
               compare_field("resolved", exp.resolved, rsp_resolved);
            end
         end
         if (req_valid && !req_stall) begin
            predict_translation(req_func, req_virt_addr, req_want_perms, req_descriptor);
         end
         // a register write lands after the beat taken at the same edge
         if (csr_write_enable) begin
            case (csr_index)
               CSR_TRANSLATE_ENABLE: walk_enable = csr_write_data[0];
               CSR_LOW_TABLE_BASE: low_base = csr_write_data;
               CSR_HIGH_TABLE_BASE: high_base = csr_write_data;
               default: ;
            endcase
         end
      end
      pending_results <= expected_walk_results.size();
      mismatch_count <= mismatches;
   end

endmodule

[bench/aarch64_table_walk_translate_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Table walk translate unit testbench
// Drives translation requests and returned descriptors into the unit: a
// directed set of corner walks, then random walks that mostly run to a block
// with faults, early blocks, abandoned walks and stray descriptors mixed in,
// across several register settings and idle patterns on both channels.
// ----------------------------------------------------------------------------
module aarch64_table_walk_translate_unit_tb;
   import atwt_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int HOLD_CYCLES  = 120;
   localparam int DRAIN_CYCLES = 8;
   localparam logic [1:0] DESC_INVALID  = 2'd0;
   localparam logic [1:0] DESC_RESERVED = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [ADDR_W-1:0] ALL_ONES = '1;
   localparam logic [PERMS_W-1:0] PERM_ALL = PERM_READ | PERM_WRITE | PERM_FETCH;
   localparam logic [PERMS_W-1:0] PERM_NONE = '0;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_func = FUNC_REQUEST;
   logic [ADDR_W-1:0]    req_virt_addr = '0;
   logic [PERMS_W-1:0]   req_want_perms = '0;
   logic [ADDR_W-1:0]    req_descriptor = '0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [ADDR_W-1:0]    csr_write_data = '0;

   logic                 req_stall;
   logic                 rsp_valid;
   logic                 rsp_kind;
   logic [ADDR_W-1:0]    rsp_read_addr;
   logic [ADDR_W-1:0]    rsp_phys_addr;
   logic [PERMS_W-1:0]   rsp_granted_perms;
   logic [FAULT_W-1:0]   rsp_fault_code;
   logic                 rsp_resolved;

   int mismatch_count;
   int pending_results;
   int send_idle_pct = 26;
   int recv_idle_pct = 69;
   int idle_phase = 0;
   int hold_left = 0;
   bit pressure_done = 1'b0;
   int cycle_count = 0;
   int beats_sent = 0;

   aarch64_table_walk_translate_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_virt_addr(req_virt_addr),
      .req_want_perms(req_want_perms),
      .req_descriptor(req_descriptor),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_read_addr(rsp_read_addr),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_granted_perms(rsp_granted_perms),
      .rsp_fault_code(rsp_fault_code),
      .rsp_resolved(rsp_resolved),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data)
   );

   aarch64_table_walk_translate_checker walk_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_virt_addr(req_virt_addr),
      .req_want_perms(req_want_perms),
      .req_descriptor(req_descriptor),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_read_addr(rsp_read_addr),
      .rsp_phys_addr(rsp_phys_addr),
      .rsp_granted_perms(rsp_granted_perms),
      .rsp_fault_code(rsp_fault_code),
      .rsp_resolved(rsp_resolved),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .mismatch_count(mismatch_count),
      .pending_results(pending_results)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold once the busy phase starts
   always @(posedge clock) begin
      if (idle_phase == 2 && !pressure_done) begin
         hold_left = HOLD_CYCLES;
         pressure_done = 1'b1;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   function automatic logic [ADDR_W-1:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic logic [ADDR_W-1:0] rand_va();
      logic [ADDR_W-1:0] va;
      va = rand64();
      case ($urandom_range(15))
         0: va = VA_HALF_SPLIT - 1;
         1: va = VA_HALF_SPLIT;
         2, 3, 4, 5, 6, 7: va[63:47] = '0;
         default: ;
      endcase
      return va;
   endfunction

   function automatic logic [ADDR_W-1:0] descriptor_of(input logic [1:0] dtype);
      logic [ADDR_W-1:0] d;
      d = rand64();
      d[1:0] = dtype;
      return d;
   endfunction

   task automatic send_beat(input logic func, input logic [ADDR_W-1:0] va,
                            input logic [PERMS_W-1:0] perms,
                            input logic [ADDR_W-1:0] desc);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_func <= func;
      req_virt_addr <= va;
      req_want_perms <= perms;
      req_descriptor <= desc;
      @(posedge clock);
      // hold the beat until the unit takes it
      while (req_stall) @(posedge clock);
      beats_sent++;
   endtask

   task automatic send_request(input logic [ADDR_W-1:0] va, input logic [PERMS_W-1:0] perms);
      send_beat(FUNC_REQUEST, va, perms, rand64());
   endtask

   task automatic send_descriptor(input logic [ADDR_W-1:0] desc);
      send_beat(FUNC_DESCRIPTOR, rand64(), PERMS_W'($urandom_range(63)), desc);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic reconfigure(input logic en, input logic [ADDR_W-1:0] low,
                              input logic [ADDR_W-1:0] high);
      logic [ADDR_W-1:0] en_word;
      drain();
      en_word = rand64();
      en_word[0] = en;
      csr_write_enable <= 1'b1;
      csr_index <= CSR_TRANSLATE_ENABLE;
      csr_write_data <= en_word;
      @(posedge clock);
      csr_index <= CSR_LOW_TABLE_BASE;
      csr_write_data <= low;
      @(posedge clock);
      csr_index <= CSR_HIGH_TABLE_BASE;
      csr_write_data <= high;
      @(posedge clock);
      csr_index <= CSR_UNUSED;
      csr_write_data <= rand64();
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic set_idling(input int phase);
      idle_phase = phase;
      case (phase)
         0: begin
            send_idle_pct = 26;
            recv_idle_pct = 69;
         end
         1: begin
            send_idle_pct = 69;
            recv_idle_pct = 26;
         end
         default: begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
      endcase
   endtask

   task automatic random_walk();
      logic [PERMS_W-1:0] perms;
      logic [1:0]         dtype;
      int                 pick;
      perms = ($urandom_range(7) == 0) ? PERM_NONE : PERMS_W'($urandom_range(63));
      send_request(rand_va(), perms);
      for (int level = 0; level < 3; level++) begin
         pick = $urandom_range(99);
         // leave the walk open now and then; the next request abandons it
         if (pick < 4) break;
         if (level < 2) begin
            dtype = pick < 80 ? DESC_TABLE : pick < 87 ? DESC_BLOCK :
                    pick < 94 ? DESC_INVALID : DESC_RESERVED;
         end else begin
            dtype = pick < 80 ? DESC_BLOCK : pick < 87 ? DESC_TABLE :
                    pick < 94 ? DESC_INVALID : DESC_RESERVED;
         end
         send_descriptor(descriptor_of(dtype));
         if (dtype != DESC_TABLE) break;
      end
   endtask

   task automatic run_random(input int budget);
      int stop_at;
      stop_at = beats_sent + budget;
      while (beats_sent < stop_at) begin
         if ($urandom_range(19) == 0) begin
            send_descriptor(rand64());
         end else begin
            random_walk();
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_idling(0);
      reconfigure(1'b1, 64'h0000_1234_5678_9abc, ALL_ONES);

      // descriptor with no walk running
      send_descriptor(ALL_ONES);
      // full walks with all-ones and all-zeros descriptors
      send_request('0, PERM_ALL);
      send_descriptor(ALL_ONES);
      send_descriptor(ALL_ONES);
      send_descriptor({{62{1'b1}}, DESC_BLOCK});
      send_request(ALL_ONES, PERM_NONE);
      send_descriptor({62'd0, DESC_TABLE});
      send_descriptor({62'd0, DESC_TABLE});
      send_descriptor({62'd0, DESC_BLOCK});
      // fault priority: write, then read, then fetch
      send_request(VA_HALF_SPLIT - 1, PERM_WRITE);
      send_descriptor(descriptor_of(DESC_INVALID));
      send_request(VA_HALF_SPLIT, PERM_READ | PERM_FETCH);
      send_descriptor(descriptor_of(DESC_TABLE));
      send_descriptor(descriptor_of(DESC_RESERVED));
      send_request(rand_va(), PERM_FETCH);
      send_descriptor(descriptor_of(DESC_INVALID));
      send_request(rand_va(), PERM_ALL);
      send_descriptor(descriptor_of(DESC_RESERVED));
      // walk failures: invalid with nothing asked, early block, table at the last level
      send_request(rand_va(), PERM_NONE);
      send_descriptor(descriptor_of(DESC_INVALID));
      send_request(rand_va(), 6'h15);
      send_descriptor(descriptor_of(DESC_BLOCK));
      send_request(rand_va(), 6'h2a);
      send_descriptor(descriptor_of(DESC_TABLE));
      send_descriptor(descriptor_of(DESC_TABLE));
      send_descriptor(descriptor_of(DESC_TABLE));
      // left open: the first random request abandons it
      send_request(rand_va(), 6'h01);
      send_descriptor(descriptor_of(DESC_TABLE));

      run_random(140);
      reconfigure(1'b1, ALL_ONES, '0);
      run_random(140);

      reconfigure(1'b0, rand64(), rand64());
      set_idling(1);
      run_random(60);
      reconfigure(1'b1, '0, ALL_ONES);
      run_random(140);

      reconfigure(1'b1, rand64(), rand64());
      set_idling(2);
      run_random(140);
      reconfigure(1'b1, rand64(), rand64());
      run_random(140);

      drain();
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[aarch64_table_walk_translate_unit.f]
+incdir+design
design/atwt_pkg.sv
design/atwt_step.sv
design/atwt_rsp_queue.sv
design/aarch64_table_walk_translate_unit.sv
bench/aarch64_table_walk_translate_checker.sv
bench/aarch64_table_walk_translate_unit_tb.sv
